>>> src/spl_pkg.sv
// Shared types and constants for the stereo peak limiter.
// Used by the interfaces, the divider and the top level. No dependencies.
package spl_pkg;

	// Default widths of the sample and gain datapaths
	localparam int SAMPLE_BITS_DEF    = 16;
	localparam int GAIN_FRAC_BITS_DEF = 24;

	// Configuration register widths
	localparam int MAX_LEVEL_W = 15;
	localparam int HOLD_W      = 16;
	localparam int REL_W       = 16;
	localparam int HOLD_CNT_W  = 17;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 8'd2;

	// Configuration reset values
	localparam logic [MAX_LEVEL_W-1:0] MAX_LEVEL_RST = 15'd32767;
	localparam logic [HOLD_W-1:0]      HOLD_RST      = 16'd4800;
	localparam logic [REL_W-1:0]       REL_RST       = 16'd4800;

	// Divider jobs: new gain (quotient below unity) or release step
	typedef enum logic {
		DIV_GAIN,
		DIV_STEP
	} div_mode_t;

	typedef struct packed {
		logic      start;
		div_mode_t mode;
	} spl_div_ctrl_t;

	// Sequencer states of the top level
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_REL,
		ST_CHK_REL,
		ST_MUL_G,
		ST_CHK_G,
		ST_DIV_GAIN,
		ST_WAIT_GAIN,
		ST_DIV_STEP,
		ST_WAIT_STEP,
		ST_MUL_L,
		ST_MUL_R,
		ST_DONE
	} state_t;

endpackage

>>> src/spl_ifs.sv
// Channel interfaces of the stereo peak limiter: sample input, result output
// and configuration write. Depends on spl_pkg.
interface spl_in_if #(
	parameter int SAMPLE_BITS = spl_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_in;
	logic signed [SAMPLE_BITS-1:0] right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface spl_out_if #(
	parameter int SAMPLE_BITS    = spl_pkg::SAMPLE_BITS_DEF,
	parameter int GAIN_FRAC_BITS = spl_pkg::GAIN_FRAC_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;
	logic [GAIN_FRAC_BITS:0]       gain_now;

	modport source (output valid, output left_out, output right_out, output gain_now,
		input ready);
	modport sink   (input valid, input left_out, input right_out, input gain_now,
		output ready);
endinterface

interface spl_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [spl_pkg::CFG_IDX_W-1:0]    index;
	logic [spl_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/spl_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Serves both the new gain and the release step. Depends on spl_pkg.
module spl_div #(
	parameter int FRAC_BITS = spl_pkg::GAIN_FRAC_BITS_DEF,
	parameter int DIV_W     = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  spl_pkg::spl_div_ctrl_t ctrl,
	input  logic [DIV_W-1:0]      rem_init,
	input  logic [FRAC_BITS:0]    dq_init,
	input  logic [DIV_W-1:0]      divisor,
	output logic                  busy,
	output logic [FRAC_BITS:0]    quot
);
	localparam int QW = FRAC_BITS + 1;
	localparam int CW = $clog2(FRAC_BITS + 2);

	logic [DIV_W-1:0] rem_q;
	logic [QW-1:0]    dq_q;
	logic [DIV_W-1:0] dv_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;

	logic [DIV_W:0]   rem_sh;
	logic [DIV_W+1:0] diff;
	logic             ge;

	// one shift-subtract step
	always_comb begin
		rem_sh = {rem_q, dq_q[QW-1]};
		diff   = {1'b0, rem_sh} - {2'b00, dv_q};
		ge     = ~diff[DIV_W+1];
	end

	// control: iteration count and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= (ctrl.mode == spl_pkg::DIV_GAIN) ? CW'(FRAC_BITS) : CW'(FRAC_BITS + 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath: remainder, dividend/quotient shifter, divisor
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q <= rem_init;
			dq_q  <= dq_init;
			dv_q  <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
			dq_q  <= {dq_q[QW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = dq_q;

endmodule

>>> src/stereo_peak_limiter.sv
// Stereo peak limiter: shared gain with hold and linear release.
// The release check runs for every input; the gain check runs too when the release check
// does not pass, and a new peak adds the gain division and the release step division.
// One item at a time: the next sample transfer is taken the cycle after the result is
// loaded, and the load waits while a held result is not yet taken.
// Reset: unity gain, zero release step, zero hold count, registers at defaults.
module stereo_peak_limiter #(
	parameter int SAMPLE_BITS    = spl_pkg::SAMPLE_BITS_DEF,
	parameter int GAIN_FRAC_BITS = spl_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	spl_in_if.sink    samples,
	spl_out_if.source results,
	spl_cfg_if.sink   cfg
);
	localparam int SB    = SAMPLE_BITS;
	localparam int F     = GAIN_FRAC_BITS;
	localparam int AW    = F + 2;
	localparam int PW    = AW + SB;
	localparam int LW    = spl_pkg::MAX_LEVEL_W + F;
	localparam int CMPW  = (PW > LW) ? PW : LW;
	localparam int DIV_W = (SB > spl_pkg::REL_W) ? SB : spl_pkg::REL_W;
	localparam logic [F:0] UNITY = {1'b1, {F{1'b0}}};

	// magnitude of a two's complement sample
	function automatic logic [SB-1:0] mag_f(input logic [SB-1:0] v);
		mag_f = v[SB-1] ? (~v + SB'(1)) : v;
	endfunction

	// floor(sample * gain / 2^F) from the magnitude product and the sign
	function automatic logic [SB-1:0] scale_f(input logic [PW-1:0] p, input logic neg);
		logic [SB-1:0] q;
		logic [SB-1:0] qa;
		q  = p[F +: SB];
		qa = q + SB'(|p[F-1:0]);
		scale_f = neg ? (~qa + SB'(1)) : q;
	endfunction

	spl_pkg::state_t state_q, state_d;

	logic [spl_pkg::MAX_LEVEL_W-1:0] max_level_q;
	logic [spl_pkg::HOLD_W-1:0]      hold_samples_q;
	logic [spl_pkg::REL_W-1:0]       release_q;

	logic [F:0]                      gain_q;
	logic [F:0]                      step_q;
	logic [spl_pkg::HOLD_CNT_W-1:0]  hold_q;

	logic          neg_l_q, neg_r_q;
	logic [SB-1:0] mag_l_q, mag_r_q, peak_q;
	logic [PW-1:0] prod_q;
	logic [SB-1:0] lres_q;

	logic          out_valid_q;
	logic [SB-1:0] out_l_q, out_r_q;
	logic [F:0]    out_g_q;

	logic [AW-1:0] op_a;
	logic [SB-1:0] op_b;
	logic          mul_en;

	logic [AW-1:0]               sum_gs;
	logic [CMPW-1:0]             lim_ext;
	logic                        fits;
	logic                        unity;
	logic [spl_pkg::HOLD_CNT_W-1:0] hold_inc;
	logic [F:0]                  gain_rel;
	logic [SB-1:0]               mag_l_in, mag_r_in;
	logic [spl_pkg::REL_W-1:0]   rel_len;

	spl_pkg::spl_div_ctrl_t div_ctrl;
	logic [DIV_W-1:0]       div_rem_init;
	logic [F:0]             div_dq_init;
	logic [DIV_W-1:0]       div_divisor;
	logic                   div_busy;
	logic [F:0]             div_quot;

	logic in_xfer, out_load;

	// shared divider
	spl_div #(
		.FRAC_BITS (F),
		.DIV_W     (DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.rem_init (div_rem_init),
		.dq_init  (div_dq_init),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quot     (div_quot)
	);

	// handshakes
	assign samples.ready     = (state_q == spl_pkg::ST_IDLE);
	assign in_xfer           = samples.valid && samples.ready;
	assign cfg.ready         = 1'b1;
	assign results.valid     = out_valid_q;
	assign results.left_out  = out_l_q;
	assign results.right_out = out_r_q;
	assign results.gain_now  = out_g_q;

	// datapath helpers
	always_comb begin
		mag_l_in = mag_f(samples.left_in);
		mag_r_in = mag_f(samples.right_in);
		sum_gs   = {1'b0, gain_q} + {1'b0, step_q};
		lim_ext  = CMPW'({max_level_q, {F{1'b0}}});
		fits     = CMPW'(prod_q) <= lim_ext;
		unity    = (gain_q == UNITY);
		hold_inc = (&hold_q) ? hold_q : hold_q + spl_pkg::HOLD_CNT_W'(1);
		gain_rel = (sum_gs > AW'(UNITY)) ? UNITY : sum_gs[F:0];
		rel_len  = (release_q == '0) ? spl_pkg::REL_W'(1) : release_q;
	end

	// sequencer: next state, multiplier operands, divider control
	always_comb begin
		state_d       = state_q;
		op_a          = '0;
		op_b          = '0;
		mul_en        = 1'b0;
		div_ctrl      = '{start: 1'b0, mode: spl_pkg::DIV_GAIN};
		div_rem_init  = DIV_W'(max_level_q);
		div_dq_init   = '0;
		div_divisor   = DIV_W'(peak_q);
		out_load      = 1'b0;
		case (state_q)
			spl_pkg::ST_IDLE: begin
				if (in_xfer) state_d = spl_pkg::ST_MUL_REL;
			end
			spl_pkg::ST_MUL_REL: begin
				op_a    = sum_gs;
				op_b    = peak_q;
				mul_en  = 1'b1;
				state_d = spl_pkg::ST_CHK_REL;
			end
			spl_pkg::ST_CHK_REL: begin
				if (!unity && fits) begin
					state_d = spl_pkg::ST_MUL_L;
				end else if (unity && (SB'(max_level_q) >= peak_q)) begin
					state_d = spl_pkg::ST_MUL_L;
				end else begin
					state_d = spl_pkg::ST_MUL_G;
				end
			end
			spl_pkg::ST_MUL_G: begin
				op_a    = {1'b0, gain_q};
				op_b    = peak_q;
				mul_en  = 1'b1;
				state_d = spl_pkg::ST_CHK_G;
			end
			spl_pkg::ST_CHK_G: begin
				state_d = fits ? spl_pkg::ST_MUL_L : spl_pkg::ST_DIV_GAIN;
			end
			spl_pkg::ST_DIV_GAIN: begin
				div_ctrl = '{start: 1'b1, mode: spl_pkg::DIV_GAIN};
				state_d  = spl_pkg::ST_WAIT_GAIN;
			end
			spl_pkg::ST_WAIT_GAIN: begin
				if (!div_busy) state_d = spl_pkg::ST_DIV_STEP;
			end
			spl_pkg::ST_DIV_STEP: begin
				div_ctrl     = '{start: 1'b1, mode: spl_pkg::DIV_STEP};
				div_rem_init = '0;
				div_dq_init  = UNITY - gain_q;
				div_divisor  = DIV_W'(rel_len);
				state_d      = spl_pkg::ST_WAIT_STEP;
			end
			spl_pkg::ST_WAIT_STEP: begin
				if (!div_busy) state_d = spl_pkg::ST_MUL_L;
			end
			spl_pkg::ST_MUL_L: begin
				op_a    = {1'b0, gain_q};
				op_b    = mag_l_q;
				mul_en  = 1'b1;
				state_d = spl_pkg::ST_MUL_R;
			end
			spl_pkg::ST_MUL_R: begin
				op_a    = {1'b0, gain_q};
				op_b    = mag_r_q;
				mul_en  = 1'b1;
				state_d = spl_pkg::ST_DONE;
			end
			spl_pkg::ST_DONE: begin
				if (!out_valid_q || results.ready) begin
					out_load = 1'b1;
					state_d  = spl_pkg::ST_IDLE;
				end
			end
			default: state_d = spl_pkg::ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= spl_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_level_q    <= spl_pkg::MAX_LEVEL_RST;
			hold_samples_q <= spl_pkg::HOLD_RST;
			release_q      <= spl_pkg::REL_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				spl_pkg::CFG_MAX_LEVEL: max_level_q    <= cfg.data[spl_pkg::MAX_LEVEL_W-1:0];
				spl_pkg::CFG_HOLD:      hold_samples_q <= cfg.data[spl_pkg::HOLD_W-1:0];
				spl_pkg::CFG_RELEASE:   release_q      <= cfg.data[spl_pkg::REL_W-1:0];
				default: ;
			endcase
		end
	end

	// limiter state: gain, release step, hold counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= UNITY;
			step_q <= '0;
			hold_q <= '0;
		end else begin
			case (state_q)
				spl_pkg::ST_CHK_REL: begin
					if (!unity && fits) begin
						hold_q <= hold_inc;
						if (hold_inc > spl_pkg::HOLD_CNT_W'(hold_samples_q)) gain_q <= gain_rel;
					end
				end
				spl_pkg::ST_CHK_G: begin
					hold_q <= '0;
				end
				spl_pkg::ST_WAIT_GAIN: begin
					if (!div_busy) gain_q <= div_quot;
				end
				spl_pkg::ST_WAIT_STEP: begin
					if (!div_busy) step_q <= div_quot;
				end
				default: ;
			endcase
		end
	end

	// sample capture, shared multiplier, left result
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			neg_l_q <= samples.left_in[SB-1];
			neg_r_q <= samples.right_in[SB-1];
			mag_l_q <= mag_l_in;
			mag_r_q <= mag_r_in;
			peak_q  <= (mag_r_in > mag_l_in) ? mag_r_in : mag_l_in;
		end
		if (mul_en) prod_q <= PW'(op_a) * PW'(op_b);
		if (state_q == spl_pkg::ST_MUL_R) lres_q <= scale_f(prod_q, neg_l_q);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_l_q <= lres_q;
			out_r_q <= scale_f(prod_q, neg_r_q);
			out_g_q <= gain_q;
		end
	end

endmodule
